// ----- rtl/dbs_pkg.sv -----
// Shared types and constants for the deduplicating block store.
// Used by dbs_ctrl, dbs_datapath and dedup_block_store; depends on nothing.
package dbs_pkg;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned BLK_W   = 8;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned REFS_W  = 9;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned BYTES_W = 24;
  localparam int unsigned KEYS    = 256;
  localparam int unsigned BLOCKS  = 256;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  // prime is 2^40 + 0x1B3: multiply as a shift plus a narrow product
  localparam logic [8:0]  FNV_LOW   = 9'h1B3;
  localparam logic [REFS_W-1:0] REFS_MAX = '1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  localparam logic [2:0] OP_BYTE    = 3'd0;
  localparam logic [2:0] OP_COMMIT  = 3'd1;
  localparam logic [2:0] OP_ERASE   = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_COMPACT = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOCHG  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [2:0]       op;
    logic [KEY_W-1:0] key_slot;
    logic [7:0]       data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BLK_W-1:0]   block_index;
    logic [SIZE_W-1:0]  payload_size;
    logic [CNT_W-1:0]   removed_count;
    logic [CNT_W-1:0]   key_count;
    logic [CNT_W-1:0]   block_count;
    logic [31:0]        dup_writes;
    logic [31:0]        ovw_writes;
    logic [31:0]        erase_count;
    logic [CNT_W-1:0]   zref_blocks;
    logic [BYTES_W-1:0] stored_bytes;
    logic [BYTES_W-1:0] zref_bytes;
  } out_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_BYTE, CMD_LATCH, CMD_LATCH_COMMIT, CMD_KEY_RD, CMD_CUR_RD,
    CMD_NOCHG_RES, CMD_NOTFOUND_RES, CMD_READ_RES, CMD_ERASE, CMD_SCAN_START,
    CMD_SCAN, CMD_FULL_RES, CMD_RELEASE_OLD, CMD_BIND, CMD_COMPACT,
    CMD_COMPACT_END, CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic key_valid;
    logic cur_valid;
    logic hash_eq;
    logic match_found;
    logic free_found;
    logic scan_done;
    logic out_busy;
  } stat_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_KEY  = 9'b000000010,
    S_CUR  = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_SCAN = 9'b000010000,
    S_BIND = 9'b000100000,
    S_CMP  = 9'b001000000,
    S_DONE = 9'b010000000,
    S_REL  = 9'b100000000
  } state_e;

endpackage

// ----- rtl/dbs_ctrl.sv -----
// Sequencer for the block store: decodes operations and steps the datapath.
// Depends on dbs_pkg.
module dbs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     in_op_i,
  output logic           in_stall_o,
  input  dbs_pkg::stat_t stat_i,
  output dbs_pkg::cmd_e  cmd_o
);

  dbs_pkg::state_e state_q, state_d;
  logic [2:0]      op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = dbs_pkg::CMD_NONE;
    case (state_q)
      dbs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_op_i;
          case (in_op_i)
            dbs_pkg::OP_BYTE: cmd_o = dbs_pkg::CMD_BYTE;
            dbs_pkg::OP_COMMIT: begin
              cmd_o   = dbs_pkg::CMD_LATCH_COMMIT;
              state_d = dbs_pkg::S_KEY;
            end
            dbs_pkg::OP_ERASE, dbs_pkg::OP_READ: begin
              cmd_o   = dbs_pkg::CMD_LATCH;
              state_d = dbs_pkg::S_KEY;
            end
            dbs_pkg::OP_COMPACT: begin
              cmd_o   = dbs_pkg::CMD_LATCH;
              state_d = dbs_pkg::S_CMP;
            end
            default: cmd_o = dbs_pkg::CMD_NONE;
          endcase
        end
      end
      dbs_pkg::S_KEY: begin
        cmd_o   = dbs_pkg::CMD_KEY_RD;
        state_d = dbs_pkg::S_CUR;
      end
      dbs_pkg::S_CUR: begin
        cmd_o   = dbs_pkg::CMD_CUR_RD;
        state_d = dbs_pkg::S_CHK;
      end
      dbs_pkg::S_CHK: begin
        state_d = dbs_pkg::S_DONE;
        case (op_q)
          dbs_pkg::OP_COMMIT: begin
            if (stat_i.key_valid && stat_i.cur_valid && stat_i.hash_eq) begin
              cmd_o = dbs_pkg::CMD_NOCHG_RES;
            end else begin
              cmd_o   = dbs_pkg::CMD_SCAN_START;
              state_d = dbs_pkg::S_SCAN;
            end
          end
          dbs_pkg::OP_ERASE: begin
            cmd_o = stat_i.key_valid ? dbs_pkg::CMD_ERASE : dbs_pkg::CMD_NOTFOUND_RES;
          end
          default: begin
            cmd_o = (stat_i.key_valid && stat_i.cur_valid) ?
                    dbs_pkg::CMD_READ_RES : dbs_pkg::CMD_NOTFOUND_RES;
          end
        endcase
      end
      dbs_pkg::S_SCAN: begin
        if (!stat_i.scan_done) begin
          cmd_o = dbs_pkg::CMD_SCAN;
        end else if (!stat_i.match_found && !stat_i.free_found) begin
          cmd_o   = dbs_pkg::CMD_FULL_RES;
          state_d = dbs_pkg::S_DONE;
        end else begin
          state_d = dbs_pkg::S_REL;
        end
      end
      dbs_pkg::S_REL: begin
        cmd_o   = dbs_pkg::CMD_RELEASE_OLD;
        state_d = dbs_pkg::S_BIND;
      end
      dbs_pkg::S_BIND: begin
        cmd_o   = dbs_pkg::CMD_BIND;
        state_d = dbs_pkg::S_DONE;
      end
      dbs_pkg::S_CMP: begin
        if (!stat_i.scan_done) begin
          cmd_o = dbs_pkg::CMD_COMPACT;
        end else begin
          cmd_o   = dbs_pkg::CMD_COMPACT_END;
          state_d = dbs_pkg::S_DONE;
        end
      end
      dbs_pkg::S_DONE: begin
        // hold until the output register is free
        if (!stat_i.out_busy) begin
          cmd_o   = dbs_pkg::CMD_EMIT;
          state_d = dbs_pkg::S_IDLE;
        end
      end
      default: state_d = dbs_pkg::S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != dbs_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbs_pkg::S_IDLE;
      op_q    <= dbs_pkg::OP_BYTE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ----- rtl/dbs_datapath.sv -----
// Datapath of the block store: hash accumulator, key and block stores,
// scan unit, statistics counters and the result register. Depends on dbs_pkg.
module dbs_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbs_pkg::cmd_e  cmd_i,
  input  dbs_pkg::in_t   in_data_i,
  output dbs_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dbs_pkg::out_t  out_data_o
);

  localparam int unsigned BW = dbs_pkg::BLK_W;
  localparam int unsigned SW = dbs_pkg::SIZE_W;
  localparam int unsigned RW = dbs_pkg::REFS_W;
  localparam int unsigned CW = dbs_pkg::CNT_W;
  localparam int unsigned YW = dbs_pkg::BYTES_W;

  // memories
  logic [BW-1:0] key_mem  [dbs_pkg::KEYS];
  logic [63:0]   hash_mem [dbs_pkg::BLOCKS];
  logic [SW-1:0] size_mem [dbs_pkg::BLOCKS];
  logic [RW-1:0] refs_mem [dbs_pkg::BLOCKS];

  logic [dbs_pkg::KEYS-1:0]   kvalid_q, kvalid_d;
  logic [dbs_pkg::BLOCKS-1:0] bvalid_q, bvalid_d;

  logic [63:0]   acc_q, acc_d, h_q, h_d, acc_x;
  logic [SW-1:0] cnt_q, cnt_d, sz_q, sz_d;
  logic [dbs_pkg::KEY_W-1:0] key_q, key_d;
  logic [BW-1:0] kblk_q;

  logic [BW-1:0] rd_addr;
  logic [63:0]   rd_hash_q;
  logic [SW-1:0] rd_size_q;
  logic [RW-1:0] rd_refs_q;
  logic [SW-1:0] cur_size_q, cur_size_d;
  logic [RW-1:0] cur_refs_q, cur_refs_d;

  logic [BW:0]   idx_q, idx_d;
  logic [BW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_vld_q, cmp_vld_d, done_q, done_d;
  logic          mfound_q, mfound_d, ffound_q, ffound_d;
  logic [BW-1:0] match_q, match_d, free_q, free_d;
  logic [CW-1:0] nrem_q, nrem_d;

  logic [CW-1:0] bound_q, bound_d, live_q, live_d, zblk_q, zblk_d;
  logic [31:0]   dup_q, dup_d, ovw_q, ovw_d, del_q, del_d;
  logic [YW-1:0] lbytes_q, lbytes_d, zbytes_q, zbytes_d;

  logic [1:0]    res_st_q, res_st_d;
  logic [BW-1:0] res_blk_q, res_blk_d;
  logic [SW-1:0] res_size_q, res_size_d;
  logic [CW-1:0] res_rem_q, res_rem_d;

  dbs_pkg::out_t out_q;
  logic          out_vld_q, out_vld_d;

  // memory write ports
  logic          key_we, hash_we, size_we, refs_we;
  logic [BW-1:0] key_wd;
  logic [dbs_pkg::KEY_W-1:0] key_wa;
  logic [BW-1:0] blk_wa, refs_wa;
  logic [RW-1:0] refs_wd;

  logic cur_valid, cmp_bvalid;

  assign cur_valid  = bvalid_q[kblk_q];
  assign cmp_bvalid = bvalid_q[cmp_idx_q];
  assign acc_x      = acc_q ^ {56'd0, in_data_i.data_byte};

  always_comb begin
    case (cmd_i)
      dbs_pkg::CMD_SCAN, dbs_pkg::CMD_COMPACT: rd_addr = idx_q[BW-1:0];
      dbs_pkg::CMD_RELEASE_OLD:                rd_addr = match_q;
      default:                                 rd_addr = kblk_q;
    endcase
  end

  always_comb begin
    kvalid_d = kvalid_q;  bvalid_d = bvalid_q;
    acc_d = acc_q;  cnt_d = cnt_q;  h_d = h_q;  sz_d = sz_q;  key_d = key_q;
    cur_size_d = cur_size_q;  cur_refs_d = cur_refs_q;
    idx_d = idx_q;  cmp_idx_d = cmp_idx_q;  cmp_vld_d = 1'b0;  done_d = done_q;
    mfound_d = mfound_q;  ffound_d = ffound_q;  match_d = match_q;  free_d = free_q;
    nrem_d = nrem_q;
    bound_d = bound_q;  live_d = live_q;  zblk_d = zblk_q;
    dup_d = dup_q;  ovw_d = ovw_q;  del_d = del_q;
    lbytes_d = lbytes_q;  zbytes_d = zbytes_q;
    res_st_d = res_st_q;  res_blk_d = res_blk_q;
    res_size_d = res_size_q;  res_rem_d = res_rem_q;
    out_vld_d = out_vld_q && out_stall_i;
    key_we = 1'b0;  key_wa = key_q;  key_wd = match_q;
    hash_we = 1'b0;  size_we = 1'b0;  blk_wa = free_q;
    refs_we = 1'b0;  refs_wa = kblk_q;  refs_wd = rd_refs_q;

    case (cmd_i)
      dbs_pkg::CMD_BYTE: begin
        acc_d = {acc_x[23:0], 40'd0} + (acc_x * {55'd0, dbs_pkg::FNV_LOW});
        if (cnt_q != dbs_pkg::SIZE_MAX) cnt_d = cnt_q + 1'b1;
      end
      dbs_pkg::CMD_LATCH, dbs_pkg::CMD_LATCH_COMMIT: begin
        key_d = in_data_i.key_slot;
        h_d   = acc_q;
        sz_d  = cnt_q;
        idx_d = '0;  done_d = 1'b0;  nrem_d = '0;
        res_st_d = dbs_pkg::ST_DONE;  res_blk_d = '0;
        res_size_d = '0;  res_rem_d = '0;
        if (cmd_i == dbs_pkg::CMD_LATCH_COMMIT) begin
          acc_d = dbs_pkg::FNV_BASIS;
          cnt_d = '0;
        end
      end
      dbs_pkg::CMD_NOCHG_RES: begin
        res_st_d = dbs_pkg::ST_NOCHG;  res_blk_d = kblk_q;  res_size_d = rd_size_q;
      end
      dbs_pkg::CMD_NOTFOUND_RES: res_st_d = dbs_pkg::ST_NOCHG;
      dbs_pkg::CMD_READ_RES: begin
        res_blk_d = kblk_q;  res_size_d = rd_size_q;
      end
      dbs_pkg::CMD_FULL_RES: res_st_d = dbs_pkg::ST_FULL;
      dbs_pkg::CMD_ERASE: begin
        if (cur_valid && rd_refs_q != '0) begin
          refs_we = 1'b1;  refs_wd = rd_refs_q - 1'b1;
          if (rd_refs_q == RW'(1)) begin
            zblk_d   = zblk_q + 1'b1;
            zbytes_d = zbytes_q + YW'(rd_size_q);
          end
        end
        kvalid_d[key_q] = 1'b0;
        bound_d = bound_q - 1'b1;
        del_d   = del_q + 1'b1;
      end
      dbs_pkg::CMD_SCAN_START: begin
        cur_size_d = rd_size_q;  cur_refs_d = rd_refs_q;
        mfound_d = 1'b0;  ffound_d = 1'b0;
        idx_d = '0;  done_d = 1'b0;
      end
      dbs_pkg::CMD_SCAN, dbs_pkg::CMD_COMPACT: begin
        if (!idx_q[BW]) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[BW-1:0];
          idx_d     = idx_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (cmp_idx_q == '1) done_d = 1'b1;
          if (cmd_i == dbs_pkg::CMD_SCAN) begin
            if (cmp_bvalid && !mfound_q && rd_hash_q == h_q) begin
              mfound_d = 1'b1;  match_d = cmp_idx_q;
            end
            if (!cmp_bvalid && !ffound_q) begin
              ffound_d = 1'b1;  free_d = cmp_idx_q;
            end
          end else if (cmp_bvalid && rd_refs_q == '0) begin
            // drop a block nobody references
            bvalid_d[cmp_idx_q] = 1'b0;
            lbytes_d = lbytes_q - YW'(rd_size_q);
            live_d   = live_q - 1'b1;
            nrem_d   = nrem_q + 1'b1;
          end
        end
      end
      dbs_pkg::CMD_COMPACT_END: begin
        zblk_d = '0;  zbytes_d = '0;  res_rem_d = nrem_q;
      end
      dbs_pkg::CMD_RELEASE_OLD: begin
        if (kvalid_q[key_q]) begin
          ovw_d = ovw_q + 1'b1;
          if (cur_valid && cur_refs_q != '0) begin
            refs_we = 1'b1;  refs_wd = cur_refs_q - 1'b1;
            if (cur_refs_q == RW'(1)) begin
              zblk_d   = zblk_q + 1'b1;
              zbytes_d = zbytes_q + YW'(cur_size_q);
            end
          end
        end else begin
          bound_d = bound_q + 1'b1;
        end
      end
      dbs_pkg::CMD_BIND: begin
        key_we = 1'b1;
        kvalid_d[key_q] = 1'b1;
        if (mfound_q) begin
          if (rd_refs_q == '0) begin
            zblk_d   = zblk_q - 1'b1;
            zbytes_d = zbytes_q - YW'(rd_size_q);
          end
          refs_we = 1'b1;  refs_wa = match_q;
          refs_wd = (rd_refs_q == dbs_pkg::REFS_MAX) ? rd_refs_q : rd_refs_q + 1'b1;
          dup_d = dup_q + 1'b1;
          res_blk_d = match_q;  res_size_d = rd_size_q;
        end else begin
          key_wd = free_q;
          bvalid_d[free_q] = 1'b1;
          hash_we = 1'b1;  size_we = 1'b1;
          refs_we = 1'b1;  refs_wa = free_q;  refs_wd = RW'(1);
          live_d   = live_q + 1'b1;
          lbytes_d = lbytes_q + YW'(sz_q);
          res_blk_d = free_q;  res_size_d = sz_q;
        end
      end
      dbs_pkg::CMD_EMIT: out_vld_d = 1'b1;
      default: ;
    endcase
  end

  // stores without reset; read data is registered
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (hash_we) hash_mem[blk_wa] <= h_q;
    if (size_we) size_mem[blk_wa] <= sz_q;
    if (refs_we) refs_mem[refs_wa] <= refs_wd;
    if (cmd_i == dbs_pkg::CMD_KEY_RD) kblk_q <= key_mem[key_q];
    rd_hash_q <= hash_mem[rd_addr];
    rd_size_q <= size_mem[rd_addr];
    rd_refs_q <= refs_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;  sz_q <= sz_d;  key_q <= key_d;
    cur_size_q <= cur_size_d;  cur_refs_q <= cur_refs_d;
    cmp_idx_q <= cmp_idx_d;  match_q <= match_d;  free_q <= free_d;
    res_st_q <= res_st_d;  res_blk_q <= res_blk_d;
    res_size_q <= res_size_d;  res_rem_q <= res_rem_d;
    if (cmd_i == dbs_pkg::CMD_EMIT) begin
      out_q.status        <= res_st_q;
      out_q.block_index   <= res_blk_q;
      out_q.payload_size  <= res_size_q;
      out_q.removed_count <= res_rem_q;
      out_q.key_count     <= bound_q;
      out_q.block_count   <= live_q;
      out_q.dup_writes    <= dup_q;
      out_q.ovw_writes    <= ovw_q;
      out_q.erase_count   <= del_q;
      out_q.zref_blocks   <= zblk_q;
      out_q.stored_bytes  <= lbytes_q;
      out_q.zref_bytes    <= zbytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvalid_q <= '0;  bvalid_q <= '0;
      acc_q <= dbs_pkg::FNV_BASIS;  cnt_q <= '0;
      idx_q <= '0;  cmp_vld_q <= 1'b0;  done_q <= 1'b0;
      mfound_q <= 1'b0;  ffound_q <= 1'b0;  nrem_q <= '0;
      bound_q <= '0;  live_q <= '0;  zblk_q <= '0;
      dup_q <= '0;  ovw_q <= '0;  del_q <= '0;
      lbytes_q <= '0;  zbytes_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      kvalid_q <= kvalid_d;  bvalid_q <= bvalid_d;
      acc_q <= acc_d;  cnt_q <= cnt_d;
      idx_q <= idx_d;  cmp_vld_q <= cmp_vld_d;  done_q <= done_d;
      mfound_q <= mfound_d;  ffound_q <= ffound_d;  nrem_q <= nrem_d;
      bound_q <= bound_d;  live_q <= live_d;  zblk_q <= zblk_d;
      dup_q <= dup_d;  ovw_q <= ovw_d;  del_q <= del_d;
      lbytes_q <= lbytes_d;  zbytes_q <= zbytes_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign stat_o.key_valid   = kvalid_q[key_q];
  assign stat_o.cur_valid   = cur_valid;
  assign stat_o.hash_eq     = (rd_hash_q == h_q);
  assign stat_o.match_found = mfound_q;
  assign stat_o.free_found  = ffound_q;
  assign stat_o.scan_done   = done_q;
  assign stat_o.out_busy    = out_vld_q && out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/dedup_block_store.sv -----
// Deduplicating block store: a payload byte gives no word. An operation
// finishes only once the output register is free to take its word. A commit
// that does not leave the key unchanged, and a compact, walk the 256-entry
// block memory, one entry per cycle through its single read port. Input is
// taken only between operations; a finished word sits in the output register
// while the next byte stream is taken.
// Top level; depends on dbs_pkg, dbs_ctrl and dbs_datapath.
module dedup_block_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dbs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dbs_pkg::out_t out_data_o
);

  dbs_pkg::cmd_e  cmd;
  dbs_pkg::stat_t stat;

  dbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- test/tb.sv -----
// Testbench for dedup_block_store: drives byte streams, commits, erases, reads
// and compacts, and checks every output word against a scoreboard predictor.
// Depends on dbs_pkg and the dedup_block_store RTL.
`timescale 1ns / 100ps

module tb;

  class store_scoreboard;
    bit            key_valid [dbs_pkg::KEYS];
    logic [7:0]    key_block [dbs_pkg::KEYS];
    bit            blk_valid [dbs_pkg::BLOCKS];
    logic [63:0]   blk_hash [dbs_pkg::BLOCKS];
    logic [15:0]   blk_size [dbs_pkg::BLOCKS];
    logic [8:0]    blk_refs [dbs_pkg::BLOCKS];
    logic [63:0]   hash_acc;
    logic [15:0]   byte_cnt;
    logic [31:0]   dup_cnt, ovw_cnt, del_cnt;
    logic [8:0]    bound_keys, live_blocks, zero_blocks;
    logic [23:0]   live_bytes, zero_bytes;
    dbs_pkg::out_t expected_words[$];
    int            errors;
    int            words_checked;

    function new();
      hash_acc = dbs_pkg::FNV_BASIS;
      byte_cnt = '0;
      dup_cnt = '0; ovw_cnt = '0; del_cnt = '0;
      bound_keys = '0; live_blocks = '0; zero_blocks = '0;
      live_bytes = '0; zero_bytes = '0;
      errors = 0;
      words_checked = 0;
      foreach (key_valid[i]) key_valid[i] = 0;
      foreach (blk_valid[i]) blk_valid[i] = 0;
    endfunction

    function void release_blk(logic [7:0] b);
      if (!blk_valid[b]) return;
      if (blk_refs[b] != 0) begin
        blk_refs[b]--;
        if (blk_refs[b] == 0) begin
          zero_blocks++;
          zero_bytes += 24'(blk_size[b]);
        end
      end
    endfunction

    function void push_word(logic [1:0] st, logic [7:0] b, logic [15:0] sz,
                            logic [8:0] removed);
      dbs_pkg::out_t w;
      w.status = st;
      w.block_index = b;
      w.payload_size = sz;
      w.removed_count = removed;
      w.key_count = bound_keys;
      w.block_count = live_blocks;
      w.dup_writes = dup_cnt;
      w.ovw_writes = ovw_cnt;
      w.erase_count = del_cnt;
      w.zref_blocks = zero_blocks;
      w.stored_bytes = live_bytes;
      w.zref_bytes = zero_bytes;
      expected_words = {expected_words, w};
    endfunction

    function void commit_key(logic [7:0] k);
      logic [63:0] h;
      logic [15:0] sz;
      int match, free_slot;
      logic [7:0] b;
      h = hash_acc;
      sz = byte_cnt;
      match = -1;
      free_slot = -1;
      hash_acc = dbs_pkg::FNV_BASIS;
      byte_cnt = '0;
      if (key_valid[k] && blk_valid[key_block[k]] && blk_hash[key_block[k]] == h) begin
        push_word(dbs_pkg::ST_NOCHG, key_block[k], blk_size[key_block[k]], '0);
        return;
      end
      for (int i = 0; i < dbs_pkg::BLOCKS; i++) begin
        if (blk_valid[i]) begin
          if (match < 0 && blk_hash[i] == h) match = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (match < 0 && free_slot < 0) begin
        push_word(dbs_pkg::ST_FULL, '0, '0, '0);
        return;
      end
      if (key_valid[k]) begin
        ovw_cnt++;
        release_blk(key_block[k]);
      end else begin
        bound_keys++;
      end
      if (match >= 0) begin
        b = 8'(match);
        if (blk_refs[b] == 0) begin
          zero_blocks--;
          zero_bytes -= 24'(blk_size[b]);
        end
        if (blk_refs[b] != dbs_pkg::REFS_MAX) blk_refs[b]++;
        dup_cnt++;
      end else begin
        b = 8'(free_slot);
        blk_valid[b] = 1;
        blk_hash[b] = h;
        blk_size[b] = sz;
        blk_refs[b] = 9'd1;
        live_blocks++;
        live_bytes += 24'(sz);
      end
      key_valid[k] = 1;
      key_block[k] = b;
      push_word(dbs_pkg::ST_DONE, b, blk_size[b], '0);
    endfunction

    // note one accepted input word
    function void note_input(dbs_pkg::in_t w);
      logic [8:0] n;
      case (w.op)
        dbs_pkg::OP_BYTE: begin
          hash_acc = (hash_acc ^ 64'(w.data_byte)) * 64'd1099511628211;
          if (byte_cnt != dbs_pkg::SIZE_MAX) byte_cnt++;
        end
        dbs_pkg::OP_COMMIT: commit_key(w.key_slot);
        dbs_pkg::OP_ERASE: begin
          if (!key_valid[w.key_slot]) begin
            push_word(dbs_pkg::ST_NOCHG, '0, '0, '0);
          end else begin
            release_blk(key_block[w.key_slot]);
            key_valid[w.key_slot] = 0;
            bound_keys--;
            del_cnt++;
            push_word(dbs_pkg::ST_DONE, '0, '0, '0);
          end
        end
        dbs_pkg::OP_READ: begin
          if (key_valid[w.key_slot] && blk_valid[key_block[w.key_slot]])
            push_word(dbs_pkg::ST_DONE, key_block[w.key_slot],
                      blk_size[key_block[w.key_slot]], '0);
          else
            push_word(dbs_pkg::ST_NOCHG, '0, '0, '0);
        end
        dbs_pkg::OP_COMPACT: begin
          n = '0;
          for (int i = 0; i < dbs_pkg::BLOCKS; i++) begin
            if (blk_valid[i] && blk_refs[i] == 0) begin
              blk_valid[i] = 0;
              live_bytes -= 24'(blk_size[i]);
              n++;
            end
          end
          live_blocks -= n;
          zero_blocks = '0;
          zero_bytes = '0;
          push_word(dbs_pkg::ST_DONE, '0, '0, n);
        end
        default: ;
      endcase
    endfunction

    function void check_word(dbs_pkg::out_t got);
      dbs_pkg::out_t exp;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected output word %h", $realtime, got);
        errors++;
        return;
      end
      exp = expected_words.pop_front();
      words_checked++;
      if (got.status !== exp.status)
        $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
      if (got.block_index !== exp.block_index)
        $display("%0t: block_index exp %0d got %0d", $realtime,
                 exp.block_index, got.block_index);
      if (got.payload_size !== exp.payload_size)
        $display("%0t: payload_size exp %0d got %0d", $realtime,
                 exp.payload_size, got.payload_size);
      if (got.removed_count !== exp.removed_count)
        $display("%0t: removed_count exp %0d got %0d", $realtime,
                 exp.removed_count, got.removed_count);
      if (got.key_count !== exp.key_count)
        $display("%0t: key_count exp %0d got %0d", $realtime,
                 exp.key_count, got.key_count);
      if (got.block_count !== exp.block_count)
        $display("%0t: block_count exp %0d got %0d", $realtime,
                 exp.block_count, got.block_count);
      if (got.dup_writes !== exp.dup_writes)
        $display("%0t: dup_writes exp %0d got %0d", $realtime,
                 exp.dup_writes, got.dup_writes);
      if (got.ovw_writes !== exp.ovw_writes)
        $display("%0t: ovw_writes exp %0d got %0d", $realtime,
                 exp.ovw_writes, got.ovw_writes);
      if (got.erase_count !== exp.erase_count)
        $display("%0t: erase_count exp %0d got %0d", $realtime,
                 exp.erase_count, got.erase_count);
      if (got.zref_blocks !== exp.zref_blocks)
        $display("%0t: zref_blocks exp %0d got %0d", $realtime,
                 exp.zref_blocks, got.zref_blocks);
      if (got.stored_bytes !== exp.stored_bytes)
        $display("%0t: stored_bytes exp %0d got %0d", $realtime,
                 exp.stored_bytes, got.stored_bytes);
      if (got.zref_bytes !== exp.zref_bytes)
        $display("%0t: zref_bytes exp %0d got %0d", $realtime,
                 exp.zref_bytes, got.zref_bytes);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  dbs_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  dbs_pkg::out_t  out_data_o;

  store_scoreboard sb;
  bit    quiet_phase;
  int    items_sent;

  dedup_block_store i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // send one word, with a random gap before it; valid stays up after it
  task automatic send_word(logic [2:0] op, logic [7:0] key, logic [7:0] data);
    dbs_pkg::in_t w;
    w.op = op;
    w.key_slot = key;
    w.data_byte = data;
    while (!quiet_phase && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
    items_sent++;
  endtask

  task automatic send_payload(int len, bit repeat_byte, logic [7:0] fill);
    for (int i = 0; i < len; i++)
      send_word(dbs_pkg::OP_BYTE, '0, repeat_byte ? fill : 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  // output side: random stall, checked at each accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_data_o);
    out_stall_i <= !quiet_phase && ($urandom_range(99) < 21);
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    int op_pick;
    sb = new();
    quiet_phase = 1'b0;
    items_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty payload, extremes of bytes and keys, all ops
    send_word(dbs_pkg::OP_READ, 8'd0, 8'd0);
    send_word(dbs_pkg::OP_ERASE, 8'd255, 8'd0);
    send_word(dbs_pkg::OP_COMMIT, 8'd0, 8'd0);
    send_word(dbs_pkg::OP_COMMIT, 8'd0, 8'd0);
    send_word(dbs_pkg::OP_BYTE, 8'd0, 8'hFF);
    send_word(dbs_pkg::OP_BYTE, 8'd0, 8'h00);
    send_word(dbs_pkg::OP_COMMIT, 8'd255, 8'd0);
    send_word(dbs_pkg::OP_BYTE, 8'd0, 8'hFF);
    send_word(dbs_pkg::OP_BYTE, 8'd0, 8'h00);
    send_word(dbs_pkg::OP_COMMIT, 8'd1, 8'd0);
    send_word(dbs_pkg::OP_READ, 8'd255, 8'd0);
    send_word(3'd5, 8'hAA, 8'h55);
    send_word(3'd7, 8'h55, 8'hAA);
    send_word(dbs_pkg::OP_COMMIT, 8'd0, 8'd0);
    send_word(dbs_pkg::OP_ERASE, 8'd0, 8'd0);
    send_word(dbs_pkg::OP_COMPACT, 8'd0, 8'd0);
    send_word(dbs_pkg::OP_ERASE, 8'd1, 8'd0);
    send_word(dbs_pkg::OP_ERASE, 8'd255, 8'd0);
    send_word(dbs_pkg::OP_COMPACT, 8'd0, 8'd0);
    send_word(3'd6, 8'd3, 8'd3);
    wait_drained();

    // run without any idling on either side
    quiet_phase = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_payload($urandom_range(3), 1'b0, 8'd0);
      send_word(dbs_pkg::OP_COMMIT, 8'($urandom_range(7)), 8'd0);
    end
    wait_drained();
    quiet_phase = 1'b0;

    // random: mostly short payloads then an operation on a small key set
    while (items_sent < 120) begin
      op_pick = $urandom_range(99);
      n = $urandom_range(15);
      if (op_pick < 50) begin
        send_payload($urandom_range(4), 1'($urandom_range(1)), 8'($urandom_range(3)));
        send_word(dbs_pkg::OP_COMMIT, 8'($urandom_range(n == 0 ? 255 : 31)),
                  8'($urandom));
      end else if (op_pick < 65) begin
        send_word(dbs_pkg::OP_ERASE, 8'($urandom_range(n == 0 ? 255 : 31)),
                  8'($urandom));
      end else if (op_pick < 85) begin
        send_word(dbs_pkg::OP_READ, 8'($urandom_range(n == 0 ? 255 : 31)),
                  8'($urandom));
      end else if (op_pick < 92) begin
        send_word(dbs_pkg::OP_COMPACT, 8'($urandom), 8'($urandom));
      end else if (op_pick < 96) begin
        send_word(3'($urandom_range(7, 5)), 8'($urandom), 8'($urandom));
      end else begin
        wait_drained();
      end
    end

    // fill the block table with distinct one-byte blocks, then overflow it
    for (int i = 0; i < 256; i++) begin
      send_word(dbs_pkg::OP_BYTE, '0, 8'(i));
      send_word(dbs_pkg::OP_COMMIT, 8'(i), 8'd0);
    end
    send_payload(5, 1'b0, 8'd0);
    send_word(dbs_pkg::OP_COMMIT, 8'd7, 8'd0);
    send_word(dbs_pkg::OP_ERASE, 8'd7, 8'd0);
    send_word(dbs_pkg::OP_ERASE, 8'd8, 8'd0);
    send_word(dbs_pkg::OP_COMPACT, 8'd0, 8'd0);

    // one longer payload of a repeated byte
    send_payload(20, 1'b1, 8'hA5);
    send_word(dbs_pkg::OP_COMMIT, 8'd200, 8'd0);
    send_word(dbs_pkg::OP_READ, 8'd200, 8'd0);

    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d input words; checked %0d output words covering commit, erase,",
             items_sent, sb.words_checked);
    $display("read, compact, full table, revive and unused op cases.");
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
